### hw/rtl/long_press_detector_macros.svh
// Assertion macros used by the long press detector top level.
`ifndef LONG_PRESS_DETECTOR_MACROS_SVH
`define LONG_PRESS_DETECTOR_MACROS_SVH

// Same-cycle implication, checked on clk, masked while rst_n is low.
`define LPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, masked while rst_n is low.
`define LPD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lpd_pkg.sv
// Package: types, codes and constants of the long press detector.
package lpd_pkg;

    localparam int FINGERS_DEF = 16;

    localparam int ID_W    = 4;
    localparam int POS_W   = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TIME     = 1'd1;

    localparam logic [POS_W-1:0]  MAX_DISTANCE_RST = 16'd328;
    localparam logic [TIME_W-1:0] MIN_TIME_RST     = 32'd1000;

    typedef enum logic [1:0] {
        FUNC_DOWN = 2'd0,
        FUNC_MOVE = 2'd1,
        FUNC_UP   = 2'd2,
        FUNC_TICK = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DOWN,
        S_UP,
        S_MV_RD,
        S_MV_DIFF,
        S_MV_SQ,
        S_MV_COMMIT,
        S_TK_SCAN,
        S_TK_EVAL,
        S_TK_FLUSH
    } state_t;

    // One finger entry as stored in the entry RAM.
    typedef struct packed {
        logic [POS_W-1:0]  start_x;
        logic [POS_W-1:0]  start_y;
        logic [POS_W-1:0]  cur_x;
        logic [POS_W-1:0]  cur_y;
        logic [TIME_W-1:0] start_time;
    } lpd_entry_t;

    typedef struct packed {
        logic latch;      // capture the input word, rewind scan
        logic down;       // write new entry, set held
        logic up;         // drop entry
        logic mv_read;    // read entry of finger
        logic mv_diff;    // register abs deltas
        logic mv_sq;      // register squares and limit
        logic mv_commit;  // compare, update or drop
        logic scan_issue; // read entry at scan index
        logic flush;      // emit pending trigger as final
    } lpd_cmd_t;

    typedef struct packed {
        logic id_ok;
        logic scan_last;
    } lpd_status_t;

endpackage

### hw/rtl/lpd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module lpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/lpd_ctrl.sv
// Controller state machine of the long press detector.
module lpd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          func,
    input  lpd_pkg::lpd_status_t status,
    output lpd_pkg::lpd_cmd_t    cmd,
    output logic                busy
);

    import lpd_pkg::*;

    state_t state_reg;
    state_t state_next;
    func_t  func_in;

    assign func_in = func_t'(func);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (func_in)
                        FUNC_DOWN: state_next = S_DOWN;
                        FUNC_MOVE: state_next = S_MV_RD;
                        FUNC_UP:   state_next = S_UP;
                        FUNC_TICK: state_next = S_TK_SCAN;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_DOWN:      state_next = S_IDLE;
            S_UP:        state_next = S_IDLE;
            S_MV_RD:     state_next = status.id_ok ? S_MV_DIFF : S_IDLE;
            S_MV_DIFF:   state_next = S_MV_SQ;
            S_MV_SQ:     state_next = S_MV_COMMIT;
            S_MV_COMMIT: state_next = S_IDLE;
            S_TK_SCAN:   state_next = status.scan_last ? S_TK_EVAL : S_TK_SCAN;
            S_TK_EVAL:   state_next = S_TK_FLUSH;
            S_TK_FLUSH:  state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy      = 1'b0;
                cmd.latch = start;
            end
            S_DOWN:      cmd.down       = status.id_ok;
            S_UP:        cmd.up         = status.id_ok;
            S_MV_RD:     cmd.mv_read    = status.id_ok;
            S_MV_DIFF:   cmd.mv_diff    = 1'b1;
            S_MV_SQ:     cmd.mv_sq      = 1'b1;
            S_MV_COMMIT: cmd.mv_commit  = 1'b1;
            S_TK_SCAN:   cmd.scan_issue = 1'b1;
            S_TK_EVAL:   cmd            = '0;
            S_TK_FLUSH:  cmd.flush      = 1'b1;
            default:     cmd            = '0;
        endcase
    end

endmodule

### hw/rtl/lpd_datapath.sv
// Datapath: config registers, held bits, entry RAM, drift and age checks.
module lpd_datapath #(
    parameter int FINGERS = lpd_pkg::FINGERS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lpd_pkg::lpd_cmd_t                   cmd,
    output lpd_pkg::lpd_status_t                status,
    input  logic [lpd_pkg::ID_W-1:0]            finger_id,
    input  logic [lpd_pkg::POS_W-1:0]           pos_x,
    input  logic [lpd_pkg::POS_W-1:0]           pos_y,
    input  logic [lpd_pkg::TIME_W-1:0]          event_time,
    input  logic                                cfg_we,
    input  logic [lpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lpd_pkg::CFG_W-1:0]           cfg_wdata,
    output logic                                result_valid,
    output logic [lpd_pkg::ID_W-1:0]            fired_finger,
    output logic [lpd_pkg::POS_W-1:0]           trigger_x,
    output logic [lpd_pkg::POS_W-1:0]           trigger_y,
    output logic                                last
);

    import lpd_pkg::*;

    localparam int IDX_W = (FINGERS > 1) ? $clog2(FINGERS) : 1;
    localparam logic [IDX_W-1:0] SCAN_END = IDX_W'(FINGERS - 1);

    // captured input word
    logic [ID_W-1:0]   id_reg;
    logic [POS_W-1:0]  px_reg;
    logic [POS_W-1:0]  py_reg;
    logic [TIME_W-1:0] now_reg;

    logic [POS_W-1:0]  max_dist_reg;
    logic [TIME_W-1:0] min_time_reg;

    logic [FINGERS-1:0] valid_reg;
    logic [FINGERS-1:0] valid_next;

    // move pipeline
    logic [POS_W-1:0]   dx_reg;
    logic [POS_W-1:0]   dy_reg;
    logic [2*POS_W-1:0] sqx_reg;
    logic [2*POS_W-1:0] sqy_reg;
    logic [2*POS_W-1:0] lim_reg;
    logic [2*POS_W:0]   d2;
    logic               mv_drop;
    logic               mv_keep;

    // tick scan
    logic [IDX_W-1:0]  scan_cnt_reg;
    logic              s1_valid_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [TIME_W-1:0] age;
    logic              tk_due;

    logic              pend_valid_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic [POS_W-1:0]  pend_x_reg;
    logic [POS_W-1:0]  pend_y_reg;

    logic              emit_mid;
    logic              emit_end;
    logic              res_valid_reg;
    logic [ID_W-1:0]   res_finger_reg;
    logic [POS_W-1:0]  res_x_reg;
    logic [POS_W-1:0]  res_y_reg;
    logic              res_last_reg;

    // entry RAM
    logic [IDX_W-1:0] id_idx;
    logic             ram_we;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    lpd_entry_t       ram_wdata;
    lpd_entry_t       rd;

    assign id_idx       = IDX_W'(id_reg);
    assign status.id_ok = (32'(id_reg) < 32'(FINGERS));
    assign status.scan_last = (scan_cnt_reg == SCAN_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg <= MAX_DISTANCE_RST;
            min_time_reg <= MIN_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_DISTANCE: max_dist_reg <= cfg_wdata[POS_W-1:0];
                REG_MIN_TIME:     min_time_reg <= cfg_wdata[TIME_W-1:0];
                default:          min_time_reg <= min_time_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            id_reg  <= finger_id;
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            now_reg <= event_time;
        end
    end

    // ---- move: |d|, squares, compare ----
    always_ff @(posedge clk)
    begin
        if (cmd.mv_diff)
        begin
            dx_reg <= (px_reg >= rd.start_x) ? px_reg - rd.start_x : rd.start_x - px_reg;
            dy_reg <= (py_reg >= rd.start_y) ? py_reg - rd.start_y : rd.start_y - py_reg;
        end
        if (cmd.mv_sq)
        begin
            sqx_reg <= (2*POS_W)'(dx_reg) * (2*POS_W)'(dx_reg);
            sqy_reg <= (2*POS_W)'(dy_reg) * (2*POS_W)'(dy_reg);
            lim_reg <= (2*POS_W)'(max_dist_reg) * (2*POS_W)'(max_dist_reg);
        end
    end

    assign d2      = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign mv_drop = d2 > {1'b0, lim_reg};
    assign mv_keep = cmd.mv_commit & valid_reg[id_idx] & ~mv_drop;

    // ---- RAM access ----
    assign ram_re    = cmd.mv_read | cmd.scan_issue;
    assign ram_raddr = cmd.scan_issue ? scan_cnt_reg : id_idx;
    assign ram_we    = cmd.down | mv_keep;

    always_comb
    begin
        ram_wdata = rd;
        if (cmd.down)
        begin
            ram_wdata.start_x    = px_reg;
            ram_wdata.start_y    = py_reg;
            ram_wdata.start_time = now_reg;
        end
        ram_wdata.cur_x = px_reg;
        ram_wdata.cur_y = py_reg;
    end

    lpd_ram #(
        .WIDTH ($bits(lpd_entry_t)),
        .DEPTH (FINGERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (id_idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd)
    );

    // ---- tick scan: one entry per cycle, one-deep pending trigger ----
    assign age    = now_reg - rd.start_time;
    assign tk_due = s1_valid_reg & valid_reg[s1_idx_reg] & (age >= min_time_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
            end
            s1_valid_reg <= cmd.scan_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_issue)
        begin
            s1_idx_reg <= scan_cnt_reg;
        end
        if (tk_due)
        begin
            pend_idx_reg <= s1_idx_reg;
            pend_x_reg   <= rd.cur_x;
            pend_y_reg   <= rd.cur_y;
        end
    end

    // held bits
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.down)
        begin
            valid_next[id_idx] = 1'b1;
        end
        if (cmd.up || (cmd.mv_commit && mv_drop))
        begin
            valid_next[id_idx] = 1'b0;
        end
        if (tk_due)
        begin
            valid_next[s1_idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (tk_due)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // ---- result register ----
    assign emit_mid = tk_due & pend_valid_reg;
    assign emit_end = cmd.flush & pend_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= emit_mid | emit_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_mid || emit_end)
        begin
            res_finger_reg <= ID_W'(pend_idx_reg);
            res_x_reg      <= pend_x_reg;
            res_y_reg      <= pend_y_reg;
            res_last_reg   <= emit_end;
        end
    end

    assign result_valid = res_valid_reg;
    assign fired_finger = res_finger_reg;
    assign trigger_x    = res_x_reg;
    assign trigger_y    = res_y_reg;
    assign last         = res_last_reg;

endmodule

### hw/rtl/long_press_detector.sv
// Long press detector: busy while a word runs; new words are taken only in S_IDLE. A
// move reads, diffs, squares and commits (stopping after the read for a bad id); a tick
// reads the entry RAM one finger entry a cycle, then flushes. Triggers of a tick leave in
// ascending finger order, one cycle each, the last one flagged; the receiver cannot stall.
// rst_n asynchronous, active low: clears held bits, config to defaults, controller idle.
module long_press_detector #(
    parameter int FINGERS = lpd_pkg::FINGERS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     func,
    input  logic [lpd_pkg::ID_W-1:0]       finger_id,
    input  logic [lpd_pkg::POS_W-1:0]      pos_x,
    input  logic [lpd_pkg::POS_W-1:0]      pos_y,
    input  logic [lpd_pkg::TIME_W-1:0]     event_time,
    // trigger words, one-cycle strobe
    output logic                           result_valid,
    output logic [lpd_pkg::ID_W-1:0]       fired_finger,
    output logic [lpd_pkg::POS_W-1:0]      trigger_x,
    output logic [lpd_pkg::POS_W-1:0]      trigger_y,
    output logic                           last,
    // config write port: 0 max_distance, 1 min_time
    input  logic                           cfg_we,
    input  logic [lpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpd_pkg::CFG_W-1:0]      cfg_wdata
);

    import lpd_pkg::*;

`include "long_press_detector_macros.svh"

    lpd_cmd_t    cmd;
    lpd_status_t status;

    // Controller sequences each word: down/up touch the held bits (and RAM on down);
    // move reads the entry, then |dx|,|dy| -> squares -> compare against max_distance^2;
    // tick walks every entry, holding one trigger back so the last can be flagged.
    lpd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lpd_datapath #(
        .FINGERS (FINGERS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .finger_id    (finger_id),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .event_time   (event_time),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .fired_finger (fired_finger),
        .trigger_x    (trigger_x),
        .trigger_y    (trigger_y),
        .last         (last)
    );

    // A taken word always raises busy in the cycle after it is taken.
    `LPD_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    // More triggers follow a non-final one, so the tick must still be running.
    `LPD_ASSERT_IMP(a_mid_busy, result_valid && !last, busy, "non-final trigger outside a tick")
    // The final trigger closes the tick: nothing follows it directly.
    `LPD_ASSERT_NXT(a_last_alone, result_valid && last, !result_valid, "trigger after final")

endmodule
